// ===== src/falru_pkg.sv =====
// Package for the fully associative LRU tag store: sizes, register codes,
// the controller state type and the structs passed between the top level and its cells.
// No dependencies.
`default_nettype none

package falru_pkg;

  localparam int LINES     = 16;
  localparam int ADDR_BITS = 32;

  localparam int ADDRESS_W   = 32;
  localparam int LINE_IDX_W  = 4;
  localparam int TOTAL_W     = 32;
  localparam int OFFSET_W    = 4;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 4;

  localparam int SEL_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int RANK_W = SEL_W;

  typedef logic [ADDR_BITS-1:0] tag_t;
  typedef logic [RANK_W-1:0]    rank_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET_BITS = CFG_INDEX_W'(0),
    REG_LRU_MODE    = CFG_INDEX_W'(1)
  } cfg_reg_t;

  localparam logic [OFFSET_W-1:0] OFFSET_BITS_RESET = OFFSET_W'(2);
  localparam logic                LRU_MODE_RESET    = 1'b1;

  typedef enum logic {
    STATE_IDLE,
    STATE_LOOKUP
  } state_t;

  // Priority chain handed from one cell to the next.
  typedef struct packed {
    logic hit;   // a lower cell already matched
    logic free;  // a lower cell is already free
  } chain_t;

  // Lookup outcome, broadcast to every cell.
  typedef struct packed {
    logic any_hit;
    logic any_free;
    logic lru_mode;
  } decide_t;

  // Update strobe and recency data, broadcast to every cell.
  typedef struct packed {
    logic  commit;
    logic  touch;
    logic  write_tag;
    logic  was_valid;
    rank_t old_rank;
  } update_t;

  // What a cell reports back.
  typedef struct packed {
    logic  sel;
    rank_t rank;
  } status_t;

endpackage

`default_nettype wire

// ===== src/falru_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on falru_pkg for field widths.
`default_nettype none

interface falru_req_if;
  logic                             valid;
  logic                             ready;
  logic [falru_pkg::ADDRESS_W-1:0]  address;

  modport source(output valid, output address, input ready);
  modport sink(input valid, input address, output ready);
endinterface

interface falru_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic                              filled;
  logic                              evicted;
  logic [falru_pkg::LINE_IDX_W-1:0]  line_index;
  logic [falru_pkg::TOTAL_W-1:0]     hit_total;
  logic [falru_pkg::TOTAL_W-1:0]     replacement_total;

  modport source(output valid, output hit, output filled, output evicted,
                 output line_index, output hit_total, output replacement_total,
                 input ready);
  modport sink(input valid, input hit, input filled, input evicted,
               input line_index, input hit_total, input replacement_total,
               output ready);
endinterface

`default_nettype wire

// ===== src/fully_associative_lru_tag_store.sv =====
// Fully associative tag store with LRU replacement, one result beat per request.
// The tag is registered when the request beat is accepted; the lookup and update then commit
// from the LOOKUP state into the result register, which drives the result beat.
// A new request is taken only in IDLE, once the row's shared lookup-and-update has committed.
// A stalled result holds the lookup cycle until the result register drains.
// Synchronous active-high reset clears valid bits, ranks, counters and restores
// offset_bits to 2 and lru_mode to 1; tags are left as they are.
`default_nettype none

module fully_associative_lru_tag_store (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  falru_req_if.sink                                 req,
  falru_rsp_if.source                               rsp,
  input  wire logic                                 cfg_write,
  input  wire logic [falru_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [falru_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [falru_pkg::OFFSET_W-1:0] offset_bits;
  logic                           lru_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= falru_pkg::OFFSET_BITS_RESET;
      lru_mode    <= falru_pkg::LRU_MODE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        falru_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data[falru_pkg::OFFSET_W-1:0];
        falru_pkg::REG_LRU_MODE:    lru_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Controller: IDLE takes a request and registers its tag, LOOKUP
  // resolves the row and commits once the result register can take the beat.
  falru_pkg::state_t state;
  falru_pkg::state_t state_next;
  falru_pkg::tag_t   tag;
  logic              commit;

  logic                      out_valid;
  logic                      out_hit;
  logic                      out_filled;
  logic                      out_evicted;
  logic [falru_pkg::LINE_IDX_W-1:0] out_line_index;
  logic [falru_pkg::TOTAL_W-1:0]    hit_counter;
  logic [falru_pkg::TOTAL_W-1:0]    replace_counter;

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    commit     = 1'b0;
    unique case (state)
      falru_pkg::STATE_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = falru_pkg::STATE_LOOKUP;
        end
      end
      falru_pkg::STATE_LOOKUP: begin
        commit = !out_valid || rsp.ready;
        if (commit) begin
          state_next = falru_pkg::STATE_IDLE;
        end
      end
      default: state_next = falru_pkg::STATE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= falru_pkg::STATE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The tag is the address, kept to ADDR_BITS, shifted right by offset_bits.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      tag <= falru_pkg::tag_t'(req.address) >> offset_bits;
    end
  end

  // Row of cells. The hit and free priority chains ripple from line 0 upward,
  // so the lowest matching or lowest free line wins.
  falru_pkg::chain_t  chain [falru_pkg::LINES+1];
  falru_pkg::status_t status [falru_pkg::LINES];
  falru_pkg::decide_t decide;
  falru_pkg::update_t update;
  logic [falru_pkg::LINES-1:0] sel_vec;

  assign chain[0] = '0;

  for (genvar i = 0; i < falru_pkg::LINES; i++) begin : g_cell
    falru_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .tag       (tag),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .decide    (decide),
      .update    (update),
      .status    (status[i])
    );
    assign sel_vec[i] = status[i].sel;
  end

  logic                   any_hit;
  logic                   any_free;
  logic                   filled;
  logic                   evicted;
  falru_pkg::rank_t       old_rank;
  logic [falru_pkg::SEL_W-1:0] sel_idx;

  always_comb begin
    any_hit  = chain[falru_pkg::LINES].hit;
    any_free = chain[falru_pkg::LINES].free;
    decide.any_hit  = any_hit;
    decide.any_free = any_free;
    decide.lru_mode = lru_mode;

    // A miss with every line occupied fills only in LRU mode, and then the
    // victim is the one line holding the largest rank.
    filled  = !any_hit && (any_free || lru_mode);
    evicted = !any_hit && !any_free;

    // At most one line is selected, so OR-reduction acts as a mux and encoder.
    old_rank = '0;
    sel_idx  = '0;
    for (int i = 0; i < falru_pkg::LINES; i++) begin
      if (sel_vec[i]) begin
        old_rank = old_rank | status[i].rank;
        sel_idx  = sel_idx | falru_pkg::SEL_W'(i);
      end
    end

    update.commit    = commit;
    update.touch     = any_hit || filled;
    update.write_tag = !any_hit;
    // The touched line was already valid on a hit or an eviction, not on a fill of a free line.
    update.was_valid = any_hit || !any_free;
    update.old_rank  = old_rank;
  end

  // Saturating counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter     <= '0;
      replace_counter <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
        if (any_hit && !(&hit_counter)) begin
          hit_counter <= hit_counter + 1'b1;
        end
        if (evicted && !(&replace_counter)) begin
          replace_counter <= replace_counter + 1'b1;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit        <= any_hit;
      out_filled     <= filled;
      out_evicted    <= evicted;
      out_line_index <= (any_hit || filled) ? falru_pkg::LINE_IDX_W'(sel_idx) : '0;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.hit               = out_hit;
  assign rsp.filled            = out_filled;
  assign rsp.evicted           = out_evicted;
  assign rsp.line_index        = out_line_index;
  assign rsp.hit_total         = hit_counter;
  assign rsp.replacement_total = replace_counter;

  // No two lines may be chosen for the same request.
  assert property (@(posedge clk) disable iff (rst) $onehot0(sel_vec))
    else $error("more than one line selected");

  // A committed lookup always shows up as a result beat in the next cycle.
  assert property (@(posedge clk) disable iff (rst) commit |=> rsp.valid)
    else $error("committed lookup produced no result beat");

  // A hit never writes a line, and an eviction never coincides with a hit.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && (rsp.filled || rsp.evicted)))
    else $error("hit reported together with fill or eviction");

  // A miss with a free line is never reported as an eviction.
  assert property (@(posedge clk) disable iff (rst)
    (commit && any_free && !any_hit) |=> !rsp.evicted)
    else $error("eviction reported while a line was free");

endmodule

`default_nettype wire

// ===== src/falru_cell.sv =====
// One line of the tag store: tag, valid bit and recency rank, with its own
// compare and its link in the first-hit / first-free priority chain. Uses falru_pkg.
`default_nettype none

module falru_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire falru_pkg::tag_t     tag,
  input  wire falru_pkg::chain_t   chain_in,
  output falru_pkg::chain_t        chain_out,
  input  wire falru_pkg::decide_t  decide,
  input  wire falru_pkg::update_t  update,
  output falru_pkg::status_t       status
);

  falru_pkg::tag_t  line_tag;
  logic             line_valid;
  falru_pkg::rank_t line_age_rank;

  logic match;
  logic free;
  logic is_lru;
  logic sel;

  always_comb begin
    match  = line_valid && (line_tag == tag);
    free   = !line_valid;
    is_lru = line_valid &&
             (line_age_rank == falru_pkg::RANK_W'(falru_pkg::LINES - 1));
    chain_out.hit  = chain_in.hit || match;
    chain_out.free = chain_in.free || free;
    priority if (decide.any_hit) begin
      sel = match && !chain_in.hit;
    end else if (decide.any_free) begin
      sel = free && !chain_in.free;
    end else begin
      sel = decide.lru_mode && is_lru;
    end
    status.sel  = sel;
    status.rank = line_age_rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid    <= 1'b0;
      line_age_rank <= '0;
    end else if (update.commit && update.touch) begin
      if (sel) begin
        line_valid    <= 1'b1;
        line_age_rank <= '0;
      end else if (line_valid &&
                   (!update.was_valid || line_age_rank < update.old_rank)) begin
        line_age_rank <= line_age_rank + 1'b1;
      end
    end
  end

  // Tags need no reset; a line's tag is only compared while it is valid.
  always_ff @(posedge clk) begin
    if (update.commit && update.touch && update.write_tag && sel) begin
      line_tag <= tag;
    end
  end

endmodule

`default_nettype wire
